// File: rtl/core/mtf_pkg.sv
package mtf_pkg;

   // alphabet and field widths
   localparam int ALPHABET_SIZE = 256;
   localparam int SYM_W         = 8;
   localparam int IDX_W         = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DEC_WAIT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // capture the input item
      logic read_pos;    // read the list at the decode position
      logic take_dec;    // latch the decoded byte as target symbol and result
      logic start_scan;  // read entry zero and seed the carry
      logic scan;        // one shift step of the move-to-front pass
      logic save_idx;    // result is the current scan position
      logic set_oob;     // result is the out-of-alphabet code
      logic emit;        // load the result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic sym_oob;     // captured byte is outside the alphabet
      logic match;       // entry read at the scan position is the target
      logic rsp_free;    // result register can take a new item
   } status_type;

endpackage

// File: rtl/core/mtf_ctrl.sv
module mtf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                direction,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mtf_pkg::status_type sts,
   output mtf_pkg::cmd_type    cmd
);

   mtf_pkg::state_type state_ff;
   mtf_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         mtf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = mtf_pkg::ST_START;
            end
         end
         mtf_pkg::ST_START: begin
            if (direction) begin
               cmd.read_pos = 1'b1;
               state_in     = mtf_pkg::ST_DEC_WAIT;
            end else if (sts.sym_oob) begin
               cmd.set_oob = 1'b1;
               state_in    = mtf_pkg::ST_FINISH;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = mtf_pkg::ST_SCAN;
            end
         end
         mtf_pkg::ST_DEC_WAIT: begin
            cmd.take_dec   = 1'b1;
            cmd.start_scan = 1'b1;
            state_in       = mtf_pkg::ST_SCAN;
         end
         mtf_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.match) begin
               cmd.save_idx = ~direction;
               state_in     = mtf_pkg::ST_FINISH;
            end
         end
         mtf_pkg::ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = mtf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/mtf_datapath.sv
module mtf_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  mtf_pkg::cmd_type                cmd,
   output mtf_pkg::status_type             sts,
   input  logic [mtf_pkg::SYM_W-1:0]       req_symbol,
   input  logic                            req_block_start,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mtf_pkg::SYM_W-1:0]       rsp_tdata
);

   localparam logic [mtf_pkg::SYM_W:0]   ALPHA_EXT = (mtf_pkg::SYM_W + 1)'(mtf_pkg::ALPHABET_SIZE);
   localparam logic [mtf_pkg::IDX_W-1:0] LAST_POS  = mtf_pkg::IDX_W'(mtf_pkg::ALPHABET_SIZE - 1);
   localparam logic [mtf_pkg::SYM_W-1:0] OOB_CODE  = mtf_pkg::SYM_W'(mtf_pkg::ALPHABET_SIZE);

   // recency list storage, entries without a valid bit read as identity
   logic [mtf_pkg::SYM_W-1:0]         list_mem [mtf_pkg::ALPHABET_SIZE];
   logic [mtf_pkg::ALPHABET_SIZE-1:0] vld_ff;

   logic [mtf_pkg::SYM_W-1:0] sym_ff;
   logic [mtf_pkg::IDX_W-1:0] idx_ff;
   logic [mtf_pkg::SYM_W-1:0] carry_ff;
   logic [mtf_pkg::SYM_W-1:0] res_ff;
   logic [mtf_pkg::SYM_W-1:0] rd_data_ff;
   logic                      rd_vld_ff;
   logic [mtf_pkg::IDX_W-1:0] rd_addr_ff;
   logic                      rsp_valid_ff;
   logic [mtf_pkg::SYM_W-1:0] rsp_data_ff;

   logic                      sym_oob;
   logic [mtf_pkg::IDX_W-1:0] pos_sat;
   logic [mtf_pkg::IDX_W-1:0] rd_addr;
   logic [mtf_pkg::SYM_W-1:0] rd_val;

   // range check and decode position saturation
   assign sym_oob = ((mtf_pkg::SYM_W + 1)'(sym_ff) >= ALPHA_EXT);
   assign pos_sat = sym_oob ? LAST_POS : sym_ff[mtf_pkg::IDX_W-1:0];

   // read address for the next cycle
   always_comb begin
      if (cmd.read_pos) begin
         rd_addr = pos_sat;
      end else if (cmd.start_scan) begin
         rd_addr = '0;
      end else begin
         rd_addr = idx_ff + 1'b1;
      end
   end

   assign rd_val = rd_vld_ff ? rd_data_ff : mtf_pkg::SYM_W'(rd_addr_ff);

   // list memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         list_mem[idx_ff] <= carry_ff;
      end
      rd_data_ff <= list_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // valid bits, cleared at once on reset or block start
   always_ff @(posedge clock) begin
      if (reset || (cmd.load && req_block_start)) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.scan) begin
            vld_ff[idx_ff] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // target symbol, scan position and carried entry
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sym_ff <= req_symbol;
      end else if (cmd.take_dec) begin
         sym_ff <= rd_val;
      end
      if (cmd.start_scan) begin
         idx_ff   <= '0;
         carry_ff <= cmd.take_dec ? rd_val : sym_ff;
      end else if (cmd.scan) begin
         idx_ff   <= idx_ff + 1'b1;
         carry_ff <= rd_val;
      end
   end

   // result value
   always_ff @(posedge clock) begin
      if (cmd.set_oob) begin
         res_ff <= OOB_CODE;
      end else if (cmd.take_dec) begin
         res_ff <= rd_val;
      end else if (cmd.save_idx) begin
         res_ff <= mtf_pkg::SYM_W'(idx_ff);
      end
   end

   // result register toward the master side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // status toward the controller
   assign sts.sym_oob  = sym_oob;
   assign sts.match    = (rd_val == sym_ff);
   assign sts.rsp_free = ~rsp_valid_ff | rsp_tready;

endmodule

// File: rtl/core/move_to_front_codec_top.sv
// Move-to-front codec over a 256-symbol recency list. The csr write channel sets the
// direction (0 encodes bytes to list positions, 1 decodes positions to bytes); write it
// only while no item is in flight. Each item runs alone: the list lives in a dual-port
// style memory with one read and one write per cycle, and the move-to-front pass walks it
// one entry per cycle from the front down to the symbol's old position p. An encode item
// passes through the start and scan states to its result in the output register; a decode
// item first reads the list at its position and waits for that read; a byte outside the
// alphabet while encoding skips the scan. The output register holds the result while
// the next item is taken in. block_start restores the identity list in the same cycle
// the item is taken, through per-entry valid bits, so there is no clearing pass after
// reset.
module move_to_front_codec_top (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data,     // direction
   // slave side
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mtf_pkg::SYM_W-1:0]     req_tdata,    // [7:0] symbol_in
   input  logic                          req_tuser,    // [0] block_start
   // master side
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mtf_pkg::SYM_W-1:0]     rsp_tdata     // [7:0] symbol_out
);

   logic                direction_ff;
   mtf_pkg::cmd_type    cmd;
   mtf_pkg::status_type sts;

   // direction register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else if (csr_valid) begin
         direction_ff <= csr_data;
      end
   end

   // controller
   mtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .direction  (direction_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // list memory and result path
   mtf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_symbol      (req_tdata),
      .req_block_start (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule
